// File: src/cmo_pkg.sv
package cmo_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_POS   = 2'd3;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       present;
    } pair_t;

    typedef struct packed {
        logic [7:0] constraint_index;
        logic [8:0] constraint_count;
        logic [1:0] status;
    } result_t;

    function automatic logic has_body(pair_t p, logic [7:0] b);
        return (p.first == b) || (p.present && (p.second == b));
    endfunction

    function automatic logic share_body(pair_t a, pair_t b);
        return has_body(b, a.first) || (a.present && has_body(b, a.second));
    endfunction

endpackage

// File: src/cmo_req_if.sv
interface cmo_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] first_body;
    logic [7:0] second_body;
    logic       second_present;
    logic [7:0] position;

    modport source (output valid, command, first_body, second_body, second_present, position,
                    input ready);
    modport sink (input valid, command, first_body, second_body, second_present, position,
                  output ready);
endinterface

// File: src/cmo_rsp_if.sv
interface cmo_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] constraint_index;
    logic [8:0] constraint_count;
    logic [1:0] status;

    modport source (output valid, constraint_index, constraint_count, status, input ready);
    modport sink (input valid, constraint_index, constraint_count, status, output ready);
endinterface

// File: src/cmo_cfg_if.sv
interface cmo_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: src/cuthill_mckee_constraint_order.sv
// Cuthill-McKee ordering of a table of one- and two-body constraints.
// Three valid/ready channels: req carries commands (clear, add, read position),
// rsp returns one beat per request beat with the index, the stored count and a
// status, and cfg writes the body count register (always ready).
// Clear, add, an out-of-range read and an unknown command are answered from
// the idle state: the result goes straight into the rsp output register, or
// waits in S_PUSH until that register frees up. A read while the order is
// current goes through S_RD, S_RDW and S_PUSH, as the order memory read is
// registered, and the next request beat is taken back in S_IDLE. The first
// in-range read after a clear or add rebuilds the order: a degree pass over
// the constraint memory, then the walk, with a seed scan per start node, a
// child scan per walked node and an insertion sort of its children by degree.
// One request is worked on at a time; a finished beat waits in the rsp output
// register while the next request beat is taken.
// When rsp is stalled, the block holds one further result internally and stops
// taking request beats until the output register frees up.
// Reset empties the table, invalidates the order and sets body count to 256.
// The memories are not cleared; only entries below the stored count are read.
module cuthill_mckee_constraint_order #(
    parameter int MAX_CONSTRAINTS = 256,
    parameter int MAX_BODIES = 256
) (
    input  logic clk,
    input  logic rst_n,
    cmo_req_if.sink   req,
    cmo_rsp_if.source rsp,
    cmo_cfg_if.sink   cfg
);
    import cmo_pkg::*;

    localparam int IW = $clog2(MAX_CONSTRAINTS);
    localparam int CW = $clog2(MAX_CONSTRAINTS + 1);
    localparam int XW = CW + 1;
    localparam int DW = CW;
    localparam int PW = (CW > 8) ? CW : 8;
    localparam logic [12:0] BODY_LIMIT = 13'(MAX_BODIES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CONSTRAINTS);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PUSH = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_RDW  = 5'd3;
    localparam logic [4:0] S_DI   = 5'd4;
    localparam logic [4:0] S_DI2  = 5'd5;
    localparam logic [4:0] S_DJ   = 5'd6;
    localparam logic [4:0] S_SD0  = 5'd7;
    localparam logic [4:0] S_SD   = 5'd8;
    localparam logic [4:0] S_SDW  = 5'd9;
    localparam logic [4:0] S_HD   = 5'd10;
    localparam logic [4:0] S_HD2  = 5'd11;
    localparam logic [4:0] S_HD3  = 5'd12;
    localparam logic [4:0] S_CH   = 5'd13;
    localparam logic [4:0] S_SO   = 5'd14;
    localparam logic [4:0] S_SO2  = 5'd15;
    localparam logic [4:0] S_SK   = 5'd16;
    localparam logic [4:0] S_SK2  = 5'd17;

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovalid_reg, ovalid_next;
    logic [8:0]    body_count_reg;
    logic [IW-1:0] pos_reg, pos_next;
    logic [XW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] eidx_reg, eidx_next;
    logic [DW-1:0] deg_reg, deg_next;
    pair_t         pair_reg, pair_next;
    logic [CW-1:0] placed_reg, placed_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] start_reg, start_next;
    logic [IW-1:0] seed_reg, seed_next;
    logic [DW-1:0] best_reg, best_next;
    logic          found_reg, found_next;
    logic [IW+DW-1:0] v_reg, v_next;
    logic [CW-1:0] k_reg, k_next;
    result_t       res_reg, res_next;
    logic          rsp_valid_reg;
    result_t       rsp_reg;

    logic          load_out;
    result_t       load_data;
    logic          out_free;

    logic          pm_we;
    logic [IW-1:0] pm_waddr, pm_raddr;
    pair_t         pm_wdata, pm_rdata;
    logic          nm_we;
    logic [IW-1:0] nm_waddr, nm_raddr;
    logic [DW:0]   nm_wdata, nm_rdata;
    logic          om_we;
    logic [IW-1:0] om_waddr, om_raddr;
    logic [IW+DW-1:0] om_wdata, om_rdata;

    logic          req_fire;
    logic          first_bad, second_bad;
    result_t       imm_res;
    logic          imm_done;
    logic          share_now;

    cmo_ram #(.WIDTH($bits(pair_t)), .DEPTH(MAX_CONSTRAINTS)) u_pair_ram (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );

    cmo_ram #(.WIDTH(DW + 1), .DEPTH(MAX_CONSTRAINTS)) u_node_ram (
        .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata),
        .raddr(nm_raddr), .rdata(nm_rdata)
    );

    cmo_ram #(.WIDTH(IW + DW), .DEPTH(MAX_CONSTRAINTS)) u_order_ram (
        .clk(clk), .we(om_we), .waddr(om_waddr), .wdata(om_wdata),
        .raddr(om_raddr), .rdata(om_rdata)
    );

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign share_now = share_body(pair_reg, pm_rdata);

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.constraint_index = rsp_reg.constraint_index;
    assign rsp.constraint_count = rsp_reg.constraint_count;
    assign rsp.status           = rsp_reg.status;

    assign first_bad  = ({1'b0, req.first_body} >= body_count_reg) ||
                        ({5'd0, req.first_body} >= BODY_LIMIT);
    assign second_bad = req.second_present &&
                        (({1'b0, req.second_body} >= body_count_reg) ||
                         ({5'd0, req.second_body} >= BODY_LIMIT));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        pos_next    = pos_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pend_next   = pend_reg;
        eidx_next   = eidx_reg;
        deg_next    = deg_reg;
        pair_next   = pair_reg;
        placed_next = placed_reg;
        head_next   = head_reg;
        start_next  = start_reg;
        seed_next   = seed_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        v_next      = v_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        load_out    = 1'b0;
        load_data   = res_reg;
        imm_res     = '0;
        imm_done    = 1'b0;
        pm_we       = 1'b0;
        pm_waddr    = count_reg[IW-1:0];
        pm_wdata    = '0;
        pm_raddr    = j_reg[IW-1:0];
        nm_we       = 1'b0;
        nm_waddr    = eidx_reg;
        nm_wdata    = '0;
        nm_raddr    = j_reg[IW-1:0];
        om_we       = 1'b0;
        om_waddr    = placed_reg[IW-1:0];
        om_wdata    = '0;
        om_raddr    = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.command)
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            ovalid_next = 1'b0;
                            imm_res     = '{8'd0, 9'd0, ST_OK};
                            imm_done    = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            imm_done = 1'b1;
                            if (count_reg >= CNT_MAX)
                            begin
                                imm_res = '{8'd0, 9'(count_reg), ST_FULL};
                            end
                            else if (first_bad || second_bad)
                            begin
                                imm_res = '{8'd0, 9'(count_reg), ST_RANGE};
                            end
                            else
                            begin
                                pm_we            = 1'b1;
                                pm_wdata.first   = req.first_body;
                                pm_wdata.second  = req.second_present ? req.second_body : 8'd0;
                                pm_wdata.present = req.second_present &&
                                                   (req.second_body != req.first_body);
                                count_next       = count_reg + 1'b1;
                                ovalid_next      = 1'b0;
                                imm_res = '{8'd0, 9'(count_reg + 1'b1), ST_OK};
                            end
                        end
                        CMD_READ:
                        begin
                            if (PW'(req.position) >= PW'(count_reg))
                            begin
                                imm_res  = '{8'd0, 9'(count_reg), ST_POS};
                                imm_done = 1'b1;
                            end
                            else
                            begin
                                pos_next = IW'(req.position);
                                if (ovalid_reg)
                                begin
                                    state_next = S_RD;
                                end
                                else
                                begin
                                    i_next      = '0;
                                    placed_next = '0;
                                    state_next  = S_DI;
                                end
                            end
                        end
                        default:
                        begin
                            imm_res  = '{8'd0, 9'(count_reg), ST_OK};
                            imm_done = 1'b1;
                        end
                    endcase
                    if (imm_done)
                    begin
                        if (out_free)
                        begin
                            load_out  = 1'b1;
                            load_data = imm_res;
                        end
                        else
                        begin
                            res_next   = imm_res;
                            state_next = S_PUSH;
                        end
                    end
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                om_raddr   = pos_reg;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                res_next   = '{8'(om_rdata[IW+DW-1:DW]), 9'(count_reg), ST_OK};
                state_next = S_PUSH;
            end
            S_DI:
            begin
                if (i_reg == XW'(count_reg))
                begin
                    state_next = S_SD0;
                end
                else
                begin
                    pm_raddr   = i_reg[IW-1:0];
                    state_next = S_DI2;
                end
            end
            S_DI2:
            begin
                pair_next  = pm_rdata;
                j_next     = '0;
                pend_next  = 1'b0;
                deg_next   = '0;
                state_next = S_DJ;
            end
            S_DJ:
            begin
                if (pend_reg && share_now)
                begin
                    deg_next = deg_reg + 1'b1;
                end
                if (j_reg != count_reg)
                begin
                    pm_raddr  = j_reg[IW-1:0];
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    nm_we      = 1'b1;
                    nm_waddr   = i_reg[IW-1:0];
                    nm_wdata   = {1'b0, deg_reg};
                    i_next     = i_reg + 1'b1;
                    state_next = S_DI;
                end
            end
            S_SD0:
            begin
                if (placed_reg == count_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_RD;
                end
                else
                begin
                    j_next     = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    state_next = S_SD;
                end
            end
            S_SD:
            begin
                if (pend_reg && !nm_rdata[DW] &&
                    (!found_reg || (nm_rdata[DW-1:0] < best_reg)))
                begin
                    best_next  = nm_rdata[DW-1:0];
                    seed_next  = eidx_reg;
                    found_next = 1'b1;
                end
                if (j_reg != count_reg)
                begin
                    nm_raddr  = j_reg[IW-1:0];
                    eidx_next = j_reg[IW-1:0];
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = S_SDW;
                end
            end
            S_SDW:
            begin
                nm_we       = 1'b1;
                nm_waddr    = seed_reg;
                nm_wdata    = {1'b1, best_reg};
                om_we       = 1'b1;
                om_waddr    = placed_reg[IW-1:0];
                om_wdata    = {seed_reg, best_reg};
                placed_next = placed_reg + 1'b1;
                head_next   = placed_reg;
                state_next  = S_HD;
            end
            S_HD:
            begin
                if (head_reg == placed_reg)
                begin
                    state_next = S_SD0;
                end
                else
                begin
                    om_raddr   = head_reg[IW-1:0];
                    state_next = S_HD2;
                end
            end
            S_HD2:
            begin
                pm_raddr   = om_rdata[IW+DW-1:DW];
                state_next = S_HD3;
            end
            S_HD3:
            begin
                pair_next  = pm_rdata;
                start_next = placed_reg;
                j_next     = '0;
                pend_next  = 1'b0;
                state_next = S_CH;
            end
            S_CH:
            begin
                if (pend_reg && !nm_rdata[DW] && share_now)
                begin
                    nm_we       = 1'b1;
                    nm_waddr    = eidx_reg;
                    nm_wdata    = {1'b1, nm_rdata[DW-1:0]};
                    om_we       = 1'b1;
                    om_waddr    = placed_reg[IW-1:0];
                    om_wdata    = {eidx_reg, nm_rdata[DW-1:0]};
                    placed_next = placed_reg + 1'b1;
                end
                if (j_reg != count_reg)
                begin
                    pm_raddr  = j_reg[IW-1:0];
                    nm_raddr  = j_reg[IW-1:0];
                    eidx_next = j_reg[IW-1:0];
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    i_next     = XW'(start_reg) + 1'b1;
                    state_next = S_SO;
                end
            end
            S_SO:
            begin
                if (i_reg >= XW'(placed_reg))
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_HD;
                end
                else
                begin
                    om_raddr   = i_reg[IW-1:0];
                    state_next = S_SO2;
                end
            end
            S_SO2:
            begin
                v_next     = om_rdata;
                k_next     = i_reg[CW-1:0];
                state_next = S_SK;
            end
            S_SK:
            begin
                if (k_reg == start_reg)
                begin
                    om_we      = 1'b1;
                    om_waddr   = k_reg[IW-1:0];
                    om_wdata   = v_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SO;
                end
                else
                begin
                    om_raddr   = IW'(k_reg - 1'b1);
                    state_next = S_SK2;
                end
            end
            S_SK2:
            begin
                om_we    = 1'b1;
                om_waddr = k_reg[IW-1:0];
                if (v_reg[DW-1:0] < om_rdata[DW-1:0])
                begin
                    om_wdata   = om_rdata;
                    k_next     = k_reg - 1'b1;
                    state_next = S_SK;
                end
                else
                begin
                    om_wdata   = v_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SO;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovalid_reg     <= 1'b0;
            body_count_reg <= 9'd256;
            rsp_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            if (cfg.valid)
            begin
                body_count_reg <= cfg.data;
            end
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        eidx_reg   <= eidx_next;
        deg_reg    <= deg_next;
        pair_reg   <= pair_next;
        placed_reg <= placed_next;
        head_reg   <= head_next;
        start_reg  <= start_next;
        seed_reg   <= seed_next;
        best_reg   <= best_next;
        v_reg      <= v_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
        if (load_out)
        begin
            rsp_reg <= load_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("stored count exceeds table depth");

    a_child_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CH && om_we) |-> (placed_reg < count_reg))
        else $error("child appended past the stored count");

    a_head_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HD) |-> (head_reg <= placed_reg))
        else $error("walk head passed the placed count");

    a_build_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SD0 && placed_reg == count_reg) |=> (ovalid_reg && state_reg == S_RD))
        else $error("finished order not marked valid");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request taken while a command is in progress");

endmodule

// File: src/cmo_ram.sv
module cmo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/sv/tb.sv
module tb;
    import cmo_pkg::*;

    typedef struct {
        bit         is_cfg;
        logic [8:0] cfg_value;
        logic [1:0] command;
        logic [7:0] first_body;
        logic [7:0] second_body;
        logic       second_present;
        logic [7:0] position;
        bit         typed;
        result_t    typed_result;
    } step_row_t;

    logic clk;
    logic rst_n;

    cmo_req_if req_ch ();
    cmo_rsp_if rsp_ch ();
    cmo_cfg_if cfg_ch ();

    cuthill_mckee_constraint_order dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state.
    logic [8:0] body_limit_reg;
    pair_t      pair_store [256];
    int         pair_total;
    int         degree_of [256];
    bit         placed_mark [256];
    logic [7:0] walk_order [256];
    bit         walk_current;

    result_t    pending_results [$];
    step_row_t  steps [$];
    int         error_count;
    int         sent_count;
    int         read_count;
    int         rebuild_count;
    int         cfg_count;
    int         phase_count;
    bit         idle_on;
    int         rsp_stall;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit bodies_meet(pair_t a, pair_t b);
        bit hit;
        hit = (a.first == b.first) || (b.present && a.first == b.second);
        if (a.present)
        begin
            hit = hit || (a.second == b.first) || (b.present && a.second == b.second);
        end
        return hit;
    endfunction

    function automatic void rebuild_walk();
        int n;
        int filled;
        int seed;
        int head;
        int lo;
        int k;
        logic [7:0] v;
        n = pair_total;
        filled = 0;
        rebuild_count++;
        for (int a = 0; a < n; a++)
        begin
            degree_of[a] = 0;
            for (int b = 0; b < n; b++)
            begin
                if (bodies_meet(pair_store[a], pair_store[b]))
                begin
                    degree_of[a]++;
                end
            end
            placed_mark[a] = 1'b0;
        end
        while (filled < n)
        begin
            seed = n;
            for (int a = 0; a < n; a++)
            begin
                if (!placed_mark[a] && (seed == n || degree_of[a] < degree_of[seed]))
                begin
                    seed = a;
                end
            end
            placed_mark[seed] = 1'b1;
            walk_order[filled] = seed[7:0];
            filled++;
            head = filled - 1;
            while (head < filled)
            begin
                lo = filled;
                for (int b = 0; b < n; b++)
                begin
                    if (!placed_mark[b] && bodies_meet(pair_store[walk_order[head]], pair_store[b]))
                    begin
                        placed_mark[b] = 1'b1;
                        walk_order[filled] = b[7:0];
                        filled++;
                    end
                end
                for (int a = lo + 1; a < filled; a++)
                begin
                    v = walk_order[a];
                    k = a;
                    while (k > lo && degree_of[v] < degree_of[walk_order[k - 1]])
                    begin
                        walk_order[k] = walk_order[k - 1];
                        k--;
                    end
                    walk_order[k] = v;
                end
                head++;
            end
        end
        walk_current = 1'b1;
    endfunction

    function automatic result_t predict_request(logic [1:0] cmd, logic [7:0] fb,
                                                logic [7:0] sb, logic sp, logic [7:0] pos);
        result_t r;
        int lim;
        r = '0;
        lim = (body_limit_reg < 256) ? body_limit_reg : 256;
        if (cmd == CMD_CLEAR)
        begin
            pair_total = 0;
            walk_current = 1'b0;
        end
        else if (cmd == CMD_ADD)
        begin
            if (pair_total >= 256)
            begin
                r.status = ST_FULL;
            end
            else if (fb >= lim || (sp && sb >= lim))
            begin
                r.status = ST_RANGE;
            end
            else
            begin
                pair_store[pair_total].first = fb;
                pair_store[pair_total].second = sp ? sb : 8'd0;
                pair_store[pair_total].present = sp && (sb != fb);
                pair_total++;
                walk_current = 1'b0;
            end
        end
        else if (cmd == CMD_READ)
        begin
            read_count++;
            if (pos >= pair_total)
            begin
                r.status = ST_POS;
            end
            else
            begin
                if (!walk_current)
                begin
                    rebuild_walk();
                end
                r.constraint_index = walk_order[pos];
            end
        end
        r.constraint_count = pair_total[8:0];
        return r;
    endfunction

    task automatic send_request(logic [1:0] cmd, logic [7:0] fb, logic [7:0] sb, logic sp,
                                logic [7:0] pos, bit typed, result_t typed_res);
        result_t r;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.first_body <= fb;
        req_ch.second_body <= sb;
        req_ch.second_present <= sp;
        req_ch.position <= pos;
        do @(posedge clk); while (!req_ch.ready);
        r = predict_request(cmd, fb, sb, sp, pos);
        pending_results.push_back(typed ? typed_res : r);
        sent_count++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_body_count(logic [8:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        body_limit_reg = value;
        cfg_count++;
    endtask

    function automatic void add_row(logic [1:0] cmd, logic [7:0] fb, logic [7:0] sb, logic sp,
                                    logic [7:0] pos, bit typed, logic [7:0] idx,
                                    logic [8:0] cnt, logic [1:0] st);
        step_row_t s;
        s = '{default: '0};
        s.command = cmd;
        s.first_body = fb;
        s.second_body = sb;
        s.second_present = sp;
        s.position = pos;
        s.typed = typed;
        s.typed_result = '{constraint_index: idx, constraint_count: cnt, status: st};
        steps.push_back(s);
    endfunction

    function automatic void add_cfg_row(logic [8:0] value);
        step_row_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.cfg_value = value;
        steps.push_back(s);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    error_count++;
                end
                else
                begin
                    result_t e;
                    e = pending_results.pop_front();
                    if (rsp_ch.constraint_index !== e.constraint_index)
                    begin
                        $error("constraint_index: expected %0d, got %0d",
                               e.constraint_index, rsp_ch.constraint_index);
                        error_count++;
                    end
                    if (rsp_ch.constraint_count !== e.constraint_count)
                    begin
                        $error("constraint_count: expected %0d, got %0d",
                               e.constraint_count, rsp_ch.constraint_count);
                        error_count++;
                    end
                    if (rsp_ch.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
                        error_count++;
                    end
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_stall = $urandom_range(0, 9);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #(12 * 30000000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int lim;
        int span;
        int base;
        int adds;
        int reads;
        logic [7:0] fb;
        logic [7:0] sb;
        logic sp;
        logic [7:0] pos;
        logic [8:0] bc;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_CLEAR;
        req_ch.first_body = '0;
        req_ch.second_body = '0;
        req_ch.second_present = 1'b0;
        req_ch.position = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        body_limit_reg = 9'd256;
        pair_total = 0;
        walk_current = 1'b0;
        error_count = 0;
        sent_count = 0;
        read_count = 0;
        rebuild_count = 0;
        cfg_count = 0;
        phase_count = 0;
        idle_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(CMD_READ, 8'd0, 8'd0, 1'b0, 8'd0, 1, 8'd0, 9'd0, ST_POS);
        add_row(2'd3, 8'd255, 8'd255, 1'b1, 8'd255, 1, 8'd0, 9'd0, ST_OK);
        add_row(CMD_ADD, 8'd0, 8'd0, 1'b0, 8'd0, 1, 8'd0, 9'd1, ST_OK);
        add_row(CMD_ADD, 8'd255, 8'd255, 1'b1, 8'd0, 1, 8'd0, 9'd2, ST_OK);
        add_row(CMD_ADD, 8'd255, 8'd0, 1'b1, 8'd0, 1, 8'd0, 9'd3, ST_OK);
        add_row(CMD_ADD, 8'hAA, 8'h55, 1'b0, 8'd0, 1, 8'd0, 9'd4, ST_OK);
        add_row(CMD_READ, 8'd0, 8'd0, 1'b0, 8'd0, 0, 8'd0, 9'd0, ST_OK);
        add_row(CMD_READ, 8'd0, 8'd0, 1'b0, 8'd3, 0, 8'd0, 9'd0, ST_OK);
        add_row(CMD_READ, 8'd0, 8'd0, 1'b0, 8'd4, 1, 8'd0, 9'd4, ST_POS);
        add_row(CMD_READ, 8'd0, 8'd0, 1'b0, 8'd255, 1, 8'd0, 9'd4, ST_POS);
        add_row(CMD_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0, 1, 8'd0, 9'd0, ST_OK);
        add_cfg_row(9'd0);
        add_row(CMD_ADD, 8'd0, 8'd0, 1'b0, 8'd0, 1, 8'd0, 9'd0, ST_RANGE);
        add_cfg_row(9'd1);
        add_row(CMD_ADD, 8'd0, 8'd0, 1'b0, 8'd0, 1, 8'd0, 9'd1, ST_OK);
        add_row(CMD_ADD, 8'd1, 8'd0, 1'b0, 8'd0, 1, 8'd0, 9'd1, ST_RANGE);
        add_row(CMD_ADD, 8'd0, 8'd1, 1'b1, 8'd0, 1, 8'd0, 9'd1, ST_RANGE);
        add_row(CMD_ADD, 8'd0, 8'd1, 1'b0, 8'd0, 1, 8'd0, 9'd2, ST_OK);
        add_row(CMD_READ, 8'd0, 8'd0, 1'b0, 8'd1, 0, 8'd0, 9'd0, ST_OK);
        add_cfg_row(9'd511);
        add_row(CMD_ADD, 8'd255, 8'd1, 1'b1, 8'd0, 1, 8'd0, 9'd3, ST_OK);
        add_row(CMD_READ, 8'd0, 8'd0, 1'b0, 8'd2, 0, 8'd0, 9'd0, ST_OK);

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
            begin
                write_body_count(steps[i].cfg_value);
            end
            else
            begin
                send_request(steps[i].command, steps[i].first_body, steps[i].second_body,
                             steps[i].second_present, steps[i].position, steps[i].typed,
                             steps[i].typed_result);
            end
        end

        // Random phases: maybe a clear, mostly related adds, then reads.
        while (sent_count < 1400)
        begin
            phase_count++;
            idle_on = (sent_count < 1150) && ($urandom_range(0, 3) != 0);
            drain_results();
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: bc = 9'd256;
                    1: bc = 9'd511;
                    2: bc = 9'd1;
                    3: bc = 9'd0;
                    default: bc = 9'($urandom_range(2, 511));
                endcase
                write_body_count(bc);
            end
            lim = (body_limit_reg < 256) ? body_limit_reg : 256;
            if ($urandom_range(0, 4) != 0)
            begin
                send_request(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom),
                             8'($urandom), 0, '0);
            end
            if (phase_count == 6)
            begin
                adds = 262;
                span = 256;
            end
            else
            begin
                adds = $urandom_range(1, 20);
                span = $urandom_range(1, 40);
            end
            if (lim != 0 && span > lim)
            begin
                span = lim;
            end
            base = (lim > span) ? $urandom_range(0, lim - span) : 0;
            for (int a = 0; a < adds; a++)
            begin
                if (lim == 0 || $urandom_range(0, 9) == 0)
                begin
                    fb = 8'($urandom);
                    sb = 8'($urandom);
                    sp = 1'($urandom);
                    send_request(2'($urandom_range(1, 3)), fb, sb, sp, 8'($urandom), 0, '0);
                end
                else
                begin
                    fb = 8'(base + $urandom_range(0, span - 1));
                    sb = 8'(base + $urandom_range(0, span - 1));
                    sp = ($urandom_range(0, 3) != 0);
                    send_request(CMD_ADD, fb, sb, sp, 8'($urandom), 0, '0);
                end
            end
            reads = $urandom_range(3, 12);
            for (int r = 0; r < reads; r++)
            begin
                if (pair_total > 0 && $urandom_range(0, 7) != 0)
                begin
                    pos = 8'($urandom_range(0, pair_total - 1));
                end
                else
                begin
                    pos = 8'($urandom);
                end
                if (phase_count == 6 && r == 0)
                begin
                    pos = 8'd255;
                end
                send_request(CMD_READ, 8'($urandom), 8'($urandom), 1'($urandom), pos, 0, '0);
            end
        end

        drain_results();
        repeat (50) @(posedge clk);
        $display("Ran %0d requests over %0d random phases, %0d of them reads.",
                 sent_count, phase_count, read_count);
        $display("The order was rebuilt %0d times across %0d body count writes.",
                 rebuild_count, cfg_count);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: cuthill_mckee_constraint_order.f
src/cmo_pkg.sv
src/cmo_req_if.sv
src/cmo_rsp_if.sv
src/cmo_cfg_if.sv
src/cmo_ram.sv
src/cuthill_mckee_constraint_order.sv
tb/sv/tb.sv
